@@ src/mbra_pkg.sv @@
// Package for the mean-baseline residual anomaly detector.
// Holds the shared widths, the register map, and the configuration and result structs.
// Has no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package mbra_pkg;

	localparam int NUM_FEATURES = 6;
	localparam int FEAT_W       = 16;
	localparam int SUM_W        = 28;
	localparam int CNT_W        = 13;
	localparam int KEEP_W       = 3;
	localparam int ENERGY_W     = 35;
	localparam int PROD_W       = 2 * FEAT_W;
	localparam int IDX_W        = $clog2(NUM_FEATURES);
	localparam int MAX_TRAINING = 4096;
	localparam int DIV_STEPS    = SUM_W;
	localparam int DIV_CNT_W    = $clog2(DIV_STEPS + 1);
	localparam int REM_W        = CNT_W;

	localparam int APB_AW = 5;
	localparam int APB_DW = 64;

	typedef enum logic [1:0] {
		REG_TRAIN_TARGET    = 2'd0,
		REG_KEPT_COMPONENTS = 2'd1,
		REG_THRESHOLD_SQ    = 2'd2
	} reg_idx_t;

	localparam logic [CNT_W-1:0]    RST_TRAIN_TARGET = CNT_W'(1024);
	localparam logic [KEEP_W-1:0]   RST_KEPT         = KEEP_W'(3);
	localparam logic [ENERGY_W-1:0] RST_THRESHOLD    = ENERGY_W'(1048576);

	typedef struct packed {
		logic [CNT_W-1:0]    train_target;
		logic [KEEP_W-1:0]   kept_components;
		logic [ENERGY_W-1:0] threshold_sq;
	} cfg_t;

	typedef struct packed {
		logic                anomaly;
		logic [ENERGY_W-1:0] residual_energy;
		logic                is_trained;
	} res_t;

endpackage
`default_nettype wire

@@ src/mean_baseline_residual_anomaly.sv @@
// Mean-baseline residual anomaly detector: channels take six unsigned Q5.11
// entropy features per transaction and give one result transaction each.
// The slave channel (s_*) carries the features in s_tdata, the master channel
// (m_*) carries residual energy in m_tdata and the anomaly and trained flags
// in m_tuser. Registers are written through the APB port at byte addresses
// 0 (training target), 8 (kept_components) and 16 (threshold_sq).
// One item is in flight at a time; s_tready is low while it is worked on.
// Training item: each feature is added to its sum, then the count is
// checked. The item that completes training with at least two items counted
// also runs the shared restoring divider once per feature for the means.
// Trained item: one multiply per residual feature through the shared 16x16
// multiplier, then the last product is added into the residual energy.
// The next transaction can be accepted in the cycle after the result leaves
// the core. The result is held in an output register, so a stalled
// m_tready stalls at most one further item. Reset clears sums, means, count
// and the trained flag at once, and restores the register defaults.
// Depends on mbra_pkg, mbra_regs, mbra_core and mbra_div.
`timescale 1ns / 1ps
`default_nettype none
module mean_baseline_residual_anomaly
	import mbra_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	// src_addr, dst_addr, src_port, dst_port, size, proto entropy, 16 bits each
	input  wire logic [95:0]       s_tdata,
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	// residual_energy [34:0], zero fill to 40 bits
	output logic      [39:0]       m_tdata,
	// anomaly [0], is_trained [1]
	output logic      [1:0]        m_tuser,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [APB_AW-1:0] paddr,
	input  wire logic [APB_DW-1:0] pwdata,
	output logic      [APB_DW-1:0] prdata,
	output logic                   pready
);

	cfg_t                             cfg;
	res_t                             res;
	res_t                             res_q;
	logic                             res_valid;
	logic                             res_ready;
	logic                             m_valid_q;
	logic [NUM_FEATURES-1:0][FEAT_W-1:0] feat;

	assign pready = 1'b1;
	assign feat   = s_tdata;

	mbra_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	mbra_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_feat   (feat),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	assign res_ready = !m_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_valid_q <= 1'b0;
		else if (res_ready)
			m_valid_q <= res_valid;
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready)
			res_q <= res;
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = 40'(res_q.residual_energy);
	assign m_tuser  = {res_q.is_trained, res_q.anomaly};

endmodule
`default_nettype wire

@@ src/mbra_regs.sv @@
// APB configuration registers of the anomaly detector.
// Uses mbra_pkg for the register map and the cfg_t struct.
`timescale 1ns / 1ps
`default_nettype none
module mbra_regs
	import mbra_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [APB_AW-1:0] paddr,
	input  wire logic [APB_DW-1:0] pwdata,
	output logic      [APB_DW-1:0] prdata,
	output cfg_t                   cfg
);

	cfg_t     cfg_q;
	reg_idx_t sel;
	logic     wr_en;

	// registers sit 8 bytes apart
	assign sel   = reg_idx_t'(paddr[4:3]);
	assign wr_en = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.train_target    <= RST_TRAIN_TARGET;
			cfg_q.kept_components <= RST_KEPT;
			cfg_q.threshold_sq    <= RST_THRESHOLD;
		end else if (wr_en) begin
			unique case (sel)
				REG_TRAIN_TARGET:    cfg_q.train_target    <= pwdata[CNT_W-1:0];
				REG_KEPT_COMPONENTS: cfg_q.kept_components <= pwdata[KEEP_W-1:0];
				REG_THRESHOLD_SQ:    cfg_q.threshold_sq    <= pwdata[ENERGY_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (sel)
			REG_TRAIN_TARGET:    prdata = APB_DW'(cfg_q.train_target);
			REG_KEPT_COMPONENTS: prdata = APB_DW'(cfg_q.kept_components);
			REG_THRESHOLD_SQ:    prdata = APB_DW'(cfg_q.threshold_sq);
			default:             prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

@@ src/mbra_div.sv @@
// Restoring divider, one quotient bit per cycle, for the baseline means.
// Uses mbra_pkg for widths.
`timescale 1ns / 1ps
`default_nettype none
module mbra_div
	import mbra_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [SUM_W-1:0] dividend,
	input  wire logic [CNT_W-1:0] divisor,
	output logic                  done,
	output logic      [SUM_W-1:0] quotient
);

	logic [SUM_W-1:0]     dq_q;
	logic [REM_W-1:0]     rem_q;
	logic [CNT_W-1:0]     dvs_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 done_q;
	logic [REM_W:0]       trial;
	logic                 ge;

	assign trial = {rem_q, dq_q[SUM_W-1]};
	assign ge    = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= DIV_CNT_W'(DIV_STEPS);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1))
					done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dq_q  <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (cnt_q != '0) begin
			rem_q <= ge ? REM_W'(trial - {1'b0, dvs_q}) : trial[REM_W-1:0];
			dq_q  <= {dq_q[SUM_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = dq_q;

endmodule
`default_nettype wire

@@ src/mbra_core.sv @@
// Sequencer of the anomaly detector: training sums, mean fixing and the
// shared multiply-accumulate over the residual features. Uses mbra_pkg and mbra_div.
`timescale 1ns / 1ps
`default_nettype none
module mbra_core
	import mbra_pkg::*;
(
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  cfg_t                                    cfg,
	input  wire logic                               in_valid,
	output logic                                    in_ready,
	input  wire logic [NUM_FEATURES-1:0][FEAT_W-1:0] in_feat,
	output logic                                    res_valid,
	input  wire logic                               res_ready,
	output res_t                                    res
);

	typedef enum logic [7:0] {
		ST_IDLE = 8'b0000_0001,
		ST_ACC  = 8'b0000_0010,
		ST_CHK  = 8'b0000_0100,
		ST_DIVS = 8'b0000_1000,
		ST_DIVW = 8'b0001_0000,
		ST_MAC  = 8'b0010_0000,
		ST_LAST = 8'b0100_0000,
		ST_DONE = 8'b1000_0000
	} state_t;

	localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(NUM_FEATURES - 1);
	localparam logic [CNT_W-1:0]  MAX_CNT  = CNT_W'(MAX_TRAINING);
	localparam logic [KEEP_W-1:0] NF_KEEP  = KEEP_W'(NUM_FEATURES);

	state_t                   state_q;
	logic [IDX_W-1:0]         idx_q;
	logic [SUM_W-1:0]         sums_q  [NUM_FEATURES];
	logic [FEAT_W-1:0]        means_q [NUM_FEATURES];
	logic [FEAT_W-1:0]        x_q     [NUM_FEATURES];
	logic [CNT_W-1:0]         count_q;
	logic                     trained_q;
	logic [ENERGY_W-1:0]      energy_q;
	logic [PROD_W-1:0]        prod_s1;
	logic                     prod_vld_s1;

	logic                     accept;
	logic [KEEP_W-1:0]        kept_eff;
	logic [CNT_W-1:0]         limit;
	logic [CNT_W-1:0]         count_inc;
	logic [FEAT_W-1:0]        cur_x;
	logic [FEAT_W-1:0]        cur_m;
	logic [FEAT_W-1:0]        diff;
	logic [ENERGY_W-1:0]      energy_add;
	logic                     div_done;
	logic [SUM_W-1:0]         div_quo;

	assign accept    = in_valid && (state_q == ST_IDLE);
	assign in_ready  = (state_q == ST_IDLE);
	assign kept_eff  = (cfg.kept_components > NF_KEEP) ? NF_KEEP : cfg.kept_components;
	assign limit     = (cfg.train_target > MAX_CNT) ? MAX_CNT : cfg.train_target;
	assign count_inc = (count_q < MAX_CNT) ? count_q + 1'b1 : count_q;
	assign cur_x     = x_q[idx_q];
	assign cur_m     = means_q[idx_q];
	assign diff      = (cur_x >= cur_m) ? cur_x - cur_m : cur_m - cur_x;
	assign energy_add = prod_vld_s1 ? energy_q + ENERGY_W'(prod_s1) : energy_q;

	mbra_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (state_q == ST_DIVS),
		.dividend (sums_q[idx_q]),
		.divisor  (count_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			count_q     <= '0;
			trained_q   <= 1'b0;
			prod_vld_s1 <= 1'b0;
			for (int i = 0; i < NUM_FEATURES; i++) begin
				sums_q[i]  <= '0;
				means_q[i] <= '0;
			end
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						prod_vld_s1 <= 1'b0;
						if (!trained_q) begin
							idx_q   <= '0;
							state_q <= ST_ACC;
						end else if (kept_eff == NF_KEEP) begin
							state_q <= ST_LAST;
						end else begin
							idx_q   <= kept_eff[IDX_W-1:0];
							state_q <= ST_MAC;
						end
					end
				end
				ST_ACC: begin
					sums_q[idx_q] <= sums_q[idx_q] + SUM_W'(cur_x);
					if (idx_q == LAST_IDX) begin
						count_q <= count_inc;
						state_q <= ST_CHK;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_CHK: begin
					if (count_q >= limit) begin
						if (count_q >= CNT_W'(2)) begin
							idx_q   <= '0;
							state_q <= ST_DIVS;
						end else begin
							trained_q <= 1'b1;
							state_q   <= ST_DONE;
						end
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_DIVS: state_q <= ST_DIVW;
				ST_DIVW: begin
					if (div_done) begin
						means_q[idx_q] <= div_quo[FEAT_W-1:0];
						if (idx_q == LAST_IDX) begin
							trained_q <= 1'b1;
							state_q   <= ST_DONE;
						end else begin
							idx_q   <= idx_q + 1'b1;
							state_q <= ST_DIVS;
						end
					end
				end
				ST_MAC: begin
					prod_vld_s1 <= 1'b1;
					if (idx_q == LAST_IDX)
						state_q <= ST_LAST;
					else
						idx_q <= idx_q + 1'b1;
				end
				ST_LAST: begin
					prod_vld_s1 <= 1'b0;
					state_q     <= ST_DONE;
				end
				ST_DONE: begin
					if (res_ready)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload: captured features, product stage and energy accumulator
	always_ff @(posedge clk) begin
		if (accept) begin
			for (int i = 0; i < NUM_FEATURES; i++)
				x_q[i] <= in_feat[i];
			energy_q <= '0;
		end else if (state_q == ST_MAC || state_q == ST_LAST) begin
			energy_q <= energy_add;
		end
		if (state_q == ST_MAC)
			prod_s1 <= diff * diff;
	end

	assign res_valid           = (state_q == ST_DONE);
	assign res.anomaly         = energy_q > cfg.threshold_sq;
	assign res.residual_energy = energy_q;
	assign res.is_trained      = trained_q;

endmodule
`default_nettype wire
